FILE: rtl/core/m3i_pkg.sv
`timescale 1ns / 1ps

package m3i_pkg;

  // default number of fraction bits of every entry
  localparam int FRAC_BITS_DEF = 16;

  // internal widths of the exact arithmetic
  localparam int ENT_W  = 32;  // one matrix entry
  localparam int PROD_W = 64;  // entry times entry
  localparam int ADJ_W  = 65;  // one cofactor, signed
  localparam int AMAG_W = 64;  // cofactor magnitude
  localparam int DET_W  = 97;  // exact determinant, signed
  localparam int DMAG_W = 96;  // determinant magnitude
  localparam int QUO_W  = 33;  // quotient magnitude bits kept before saturation
  localparam int DIV_LAT = QUO_W + 1;  // divider register stages

  localparam int N_ENT = 9;

  typedef logic signed [ENT_W-1:0] ent_t;

  // operand indexes of each cofactor: p*q - s*t, entries in row-major order
  localparam int COF_IDX [N_ENT][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  localparam ent_t SAT_MAX = 32'h7FFF_FFFF;
  localparam ent_t SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    ent_t in_r0c0;
    ent_t in_r0c1;
    ent_t in_r0c2;
    ent_t in_r1c0;
    ent_t in_r1c1;
    ent_t in_r1c2;
    ent_t in_r2c0;
    ent_t in_r2c1;
    ent_t in_r2c2;
  } in_word_t;

  typedef struct packed {
    ent_t inv_r0c0;
    ent_t inv_r0c1;
    ent_t inv_r0c2;
    ent_t inv_r1c0;
    ent_t inv_r1c1;
    ent_t inv_r1c2;
    ent_t inv_r2c0;
    ent_t inv_r2c1;
    ent_t inv_r2c2;
    ent_t det_value;
    logic singular;
  } out_word_t;

  // per-item flags that ride alongside the dividers
  typedef struct packed {
    logic             singular;
    logic             dneg;
    logic [N_ENT-1:0] nneg;
    ent_t             det_value;
  } side_t;

endpackage

FILE: rtl/core/m3i_if.sv
`timescale 1ns / 1ps

// input channel: one matrix per word
interface m3i_in_if;
  logic               valid;
  logic               ready;
  m3i_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// output channel: one inverse per word
interface m3i_out_if;
  logic               valid;
  logic               ready;
  m3i_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/m3i_div.sv
`timescale 1ns / 1ps

// pipelined restoring divider of magnitudes, one quotient bit per stage
module m3i_div #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [m3i_pkg::AMAG_W+2*FRAC_BITS-1:0] num_i,
  input  logic [m3i_pkg::DMAG_W-1:0]             den_i,
  output logic [m3i_pkg::QUO_W-1:0]              quo_o,
  output logic                                   ovf_o
);

  localparam int NUM_W = m3i_pkg::AMAG_W + 2 * FRAC_BITS;
  localparam int QW    = m3i_pkg::QUO_W;
  localparam int DW    = m3i_pkg::DMAG_W;
  localparam int WW    = ((NUM_W > DW + QW) ? NUM_W : DW + QW) + 1;

  logic [WW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  // entry stage: flag quotients that do not fit the kept bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= WW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (WW'(num_i) >= (WW'(den_i) << QW));
    end
  end

  // one trial subtract per stage, msb first
  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int B = QW - s;
    logic [WW-1:0] dsh;
    logic          fits;
    assign dsh  = WW'(den_q[s-1]) << B;
    assign fits = (rem_q[s-1] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= fits ? (rem_q[s-1] - dsh) : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= quo_q[s-1] | (fits ? (QW'(1) << B) : '0);
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

FILE: rtl/core/matrix3_inverse.sv
`timescale 1ns / 1ps

// channel  | dir | modport | word
// ---------+-----+---------+----------------------------------------------
// in_i     | in  | sink    | 3x3 matrix, signed fixed point, row-major
// out_o    | out | source  | 3x3 inverse, saturated determinant, singular
//
// one matrix accepted per cycle while the output is not stalled, one result per matrix, in order
// the pipeline holds 5 arithmetic stages, 34 divider stages and the output register
// the nine pipelined dividers (one quotient bit per stage) set the depth
// reset clears only the valid bits; the datapath registers are not reset
// a stall on the output freezes every stage; nothing is dropped or repeated
module matrix3_inverse #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  m3i_in_if.sink     in_i,
  m3i_out_if.source  out_o
);

  localparam int NE     = m3i_pkg::N_ENT;
  localparam int NUM_W  = m3i_pkg::AMAG_W + 2 * FRAC_BITS;
  localparam int DET_W  = m3i_pkg::DET_W;
  localparam int ADJ_W  = m3i_pkg::ADJ_W;
  localparam int PROD_W = m3i_pkg::PROD_W;
  localparam int LAT    = m3i_pkg::DIV_LAT;
  localparam int QW     = m3i_pkg::QUO_W;

  logic en;
  m3i_pkg::ent_t a [NE];

  // whole pipeline moves when the output register is free or drained
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  assign a[0] = in_i.data.in_r0c0;
  assign a[1] = in_i.data.in_r0c1;
  assign a[2] = in_i.data.in_r0c2;
  assign a[3] = in_i.data.in_r1c0;
  assign a[4] = in_i.data.in_r1c1;
  assign a[5] = in_i.data.in_r1c2;
  assign a[6] = in_i.data.in_r2c0;
  assign a[7] = in_i.data.in_r2c1;
  assign a[8] = in_i.data.in_r2c2;

  // valid bits of the arithmetic stages
  logic [4:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_i.valid};
    end
  end

  // stage 1: cofactor products, first row kept for the determinant
  logic signed [PROD_W-1:0] pp_q [NE];
  logic signed [PROD_W-1:0] pn_q [NE];
  m3i_pkg::ent_t            row1_q [3];
  m3i_pkg::ent_t            row2_q [3];

  for (genvar k = 0; k < NE; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (en) begin
        pp_q[k] <= a[m3i_pkg::COF_IDX[k][0]] * a[m3i_pkg::COF_IDX[k][1]];
        pn_q[k] <= a[m3i_pkg::COF_IDX[k][2]] * a[m3i_pkg::COF_IDX[k][3]];
      end
    end
  end

  // stage 2: cofactors
  logic signed [ADJ_W-1:0] adj2_q [NE];
  logic signed [ADJ_W-1:0] adj3_q [NE];
  logic signed [ADJ_W-1:0] adj4_q [NE];
  logic signed [ADJ_W-1:0] adj5_q [NE];

  for (genvar k = 0; k < NE; k++) begin : g_adj
    always_ff @(posedge clk_i) begin
      if (en) begin
        adj2_q[k] <= $signed({pp_q[k][PROD_W-1], pp_q[k]})
                   - $signed({pn_q[k][PROD_W-1], pn_q[k]});
        adj3_q[k] <= adj2_q[k];
        adj4_q[k] <= adj3_q[k];
        adj5_q[k] <= adj4_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      row1_q <= a[0:2];
      row2_q <= row1_q;
    end
  end

  // stage 3: first-row times cofactor, split into two partial products
  // stage 4: partials combined; stage 5: expansion sum
  logic signed [65:0]      pl_q [3];
  logic signed [63:0]      ph_q [3];
  logic signed [DET_W-1:0] term_q [3];
  logic signed [DET_W-1:0] det_q;

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (en) begin
        pl_q[j]   <= row2_q[j] * $signed({1'b0, adj2_q[3*j][32:0]});
        ph_q[j]   <= row2_q[j] * $signed(adj2_q[3*j][ADJ_W-1:33]);
        term_q[j] <= $signed({ph_q[j], 33'b0}) + $signed({{31{pl_q[j][65]}}, pl_q[j]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= term_q[0] + term_q[1] + term_q[2];
    end
  end

  // divider operands and the flags that travel beside them
  logic signed [DET_W-1:0] det_abs;
  logic signed [DET_W-1:0] det_sh;
  logic                    det_fits;
  m3i_pkg::side_t          side_d;
  logic [NUM_W-1:0]        num [NE];
  logic [QW-1:0]           quo [NE];
  logic                    ovf [NE];

  assign det_abs  = det_q[DET_W-1] ? -det_q : det_q;
  assign det_sh   = det_q >>> (2 * FRAC_BITS);
  assign det_fits = (&det_sh[DET_W-1:31]) || !(|det_sh[DET_W-1:31]);

  always_comb begin
    side_d.singular = (det_q == '0);
    side_d.dneg     = det_q[DET_W-1];
    for (int k = 0; k < NE; k++) begin
      side_d.nneg[k] = adj5_q[k][ADJ_W-1];
    end
    if (det_fits) begin
      side_d.det_value = det_sh[31:0];
    end else begin
      side_d.det_value = det_q[DET_W-1] ? m3i_pkg::SAT_MIN : m3i_pkg::SAT_MAX;
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_div
    logic [ADJ_W-1:0] amag;
    assign amag   = adj5_q[k][ADJ_W-1] ? -adj5_q[k] : adj5_q[k];
    assign num[k] = {amag[m3i_pkg::AMAG_W-1:0], (2 * FRAC_BITS)'(0)};

    m3i_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[k]),
      .den_i (det_abs[m3i_pkg::DMAG_W-1:0]),
      .quo_o (quo[k]),
      .ovf_o (ovf[k])
    );
  end

  // flags delayed to match the divider depth
  m3i_pkg::side_t side_q [LAT];
  logic [LAT-1:0] svld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svld_q <= '0;
    end else if (en) begin
      svld_q <= {svld_q[LAT-2:0], vld_q[4]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int s = 1; s < LAT; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // sign, saturation and singular masking into the output register
  m3i_pkg::ent_t     inv [NE];
  m3i_pkg::side_t    sf;
  m3i_pkg::out_word_t out_d;
  m3i_pkg::out_word_t out_q;
  logic              out_valid_q;

  assign sf = side_q[LAT-1];

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      if (sf.singular) begin
        inv[k] = '0;
      end else if (sf.nneg[k] ^ sf.dneg) begin
        if (ovf[k] || (quo[k] > QW'(33'h0_8000_0000))) begin
          inv[k] = m3i_pkg::SAT_MIN;
        end else begin
          inv[k] = -quo[k][31:0];
        end
      end else begin
        if (ovf[k] || (quo[k] > QW'(33'h0_7FFF_FFFF))) begin
          inv[k] = m3i_pkg::SAT_MAX;
        end else begin
          inv[k] = quo[k][31:0];
        end
      end
    end
    out_d.inv_r0c0  = inv[0];
    out_d.inv_r0c1  = inv[1];
    out_d.inv_r0c2  = inv[2];
    out_d.inv_r1c0  = inv[3];
    out_d.inv_r1c1  = inv[4];
    out_d.inv_r1c2  = inv[5];
    out_d.inv_r2c0  = inv[6];
    out_d.inv_r2c1  = inv[7];
    out_d.inv_r2c2  = inv[8];
    out_d.det_value = sf.singular ? '0 : sf.det_value;
    out_d.singular  = sf.singular;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= svld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.singular |->
      out_o.data.det_value == '0 && out_o.data.inv_r0c0 == '0 &&
      out_o.data.inv_r1c1 == '0 && out_o.data.inv_r2c2 == '0)
    else $error("singular result carries nonzero fields");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("stalled result changed");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("input ready out of step with output stall");
`endif

endmodule

FILE: tb/matrix3_inverse_checker.sv
`timescale 1ns / 1ps

module matrix3_inverse_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  m3i_in_if         in_mon,
  m3i_out_if        out_mon,
  output int        mismatch_count_o,
  output int        pending_o
);

  localparam int FRAC = m3i_pkg::FRAC_BITS_DEF;

  typedef logic signed [199:0] exact_t;

  m3i_pkg::out_word_t inverse_q[$];

  string field_names [10] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2", "inv_r1c0", "inv_r1c1",
                              "inv_r1c2", "inv_r2c0", "inv_r2c1", "inv_r2c2", "det_value"};

  // clamp an exact value to the signed 32-bit range
  function automatic m3i_pkg::ent_t clamp32(exact_t v);
    if (v > exact_t'(m3i_pkg::SAT_MAX)) return m3i_pkg::SAT_MAX;
    if (v < exact_t'(m3i_pkg::SAT_MIN)) return m3i_pkg::SAT_MIN;
    return m3i_pkg::ent_t'(v);
  endfunction

  // exact adjugate over exact determinant, one rounding at the end
  function automatic m3i_pkg::out_word_t invert(m3i_pkg::in_word_t w);
    exact_t             a [9];
    exact_t             adj [9];
    exact_t             det;
    m3i_pkg::ent_t      q [9];
    m3i_pkg::out_word_t r;
    a[0] = w.in_r0c0; a[1] = w.in_r0c1; a[2] = w.in_r0c2;
    a[3] = w.in_r1c0; a[4] = w.in_r1c1; a[5] = w.in_r1c2;
    a[6] = w.in_r2c0; a[7] = w.in_r2c1; a[8] = w.in_r2c2;
    adj[0] = a[4] * a[8] - a[5] * a[7];
    adj[1] = a[2] * a[7] - a[1] * a[8];
    adj[2] = a[1] * a[5] - a[2] * a[4];
    adj[3] = a[5] * a[6] - a[3] * a[8];
    adj[4] = a[0] * a[8] - a[2] * a[6];
    adj[5] = a[2] * a[3] - a[0] * a[5];
    adj[6] = a[3] * a[7] - a[4] * a[6];
    adj[7] = a[1] * a[6] - a[0] * a[7];
    adj[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    // signed division truncates toward zero
    for (int k = 0; k < 9; k++) q[k] = clamp32((adj[k] <<< (2 * FRAC)) / det);
    r.inv_r0c0 = q[0]; r.inv_r0c1 = q[1]; r.inv_r0c2 = q[2];
    r.inv_r1c0 = q[3]; r.inv_r1c1 = q[4]; r.inv_r1c2 = q[5];
    r.inv_r2c0 = q[6]; r.inv_r2c1 = q[7]; r.inv_r2c2 = q[8];
    r.det_value = clamp32(det >>> (2 * FRAC));
    return r;
  endfunction

  assign pending_o = inverse_q.size();

  // predict on accepted input words, compare accepted output words
  always @(posedge clk_i or negedge rst_ni) begin
    m3i_pkg::out_word_t exp_w;
    logic [$bits(m3i_pkg::out_word_t)-1:0] eb, ab;
    if (!rst_ni) begin
      inverse_q.delete();
      mismatch_count_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) inverse_q.push_back(invert(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        if (inverse_q.size() == 0) begin
          $error("result word with no matrix waiting");
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_w = inverse_q.pop_front();
          eb = exp_w;
          ab = out_mon.data;
          if (eb != ab) mismatch_count_o <= mismatch_count_o + 1;
          for (int k = 0; k < 10; k++) begin
            if (eb[$bits(m3i_pkg::out_word_t)-1-32*k -: 32] !=
                ab[$bits(m3i_pkg::out_word_t)-1-32*k -: 32])
              $error("%s expected %h actual %h", field_names[k],
                     eb[$bits(m3i_pkg::out_word_t)-1-32*k -: 32],
                     ab[$bits(m3i_pkg::out_word_t)-1-32*k -: 32]);
          end
          if (exp_w.singular != out_mon.data.singular)
            $error("singular expected %b actual %b", exp_w.singular, out_mon.data.singular);
        end
      end
    end
  end

endmodule

FILE: tb/matrix3_inverse_test.sv
`timescale 1ns / 1ps

module matrix3_inverse_test;

  localparam int            RANDOM_WORDS = 1450;
  localparam int            CYCLE_LIMIT  = 400000;
  localparam m3i_pkg::ent_t ONE = 32'sh0001_0000;
  localparam m3i_pkg::ent_t SMAX = m3i_pkg::SAT_MAX;
  localparam m3i_pkg::ent_t SMIN = m3i_pkg::SAT_MIN;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatch_count;
  int   pending;
  int   cycle_count = 0;

  m3i_in_if  in_ch ();
  m3i_out_if out_ch ();

  matrix3_inverse DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  matrix3_inverse_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern: phases of no stall, light and heavy stall
  int stall_phase = 0;
  int phase_left = 0;
  always @(posedge clk_i) begin
    if (phase_left == 0) begin
      stall_phase <= $urandom_range(0, 2);
      phase_left  <= $urandom_range(5, 80);
    end else begin
      phase_left <= phase_left - 1;
    end
    case (stall_phase)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  int burst_left = 0;

  // one word on the input channel, then maybe a gap
  task automatic send_matrix(m3i_pkg::in_word_t w);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic m3i_pkg::in_word_t pack9(
    m3i_pkg::ent_t e0, m3i_pkg::ent_t e1, m3i_pkg::ent_t e2,
    m3i_pkg::ent_t e3, m3i_pkg::ent_t e4, m3i_pkg::ent_t e5,
    m3i_pkg::ent_t e6, m3i_pkg::ent_t e7, m3i_pkg::ent_t e8);
    return '{e0, e1, e2, e3, e4, e5, e6, e7, e8};
  endfunction

  function automatic m3i_pkg::ent_t small_entry();
    return m3i_pkg::ent_t'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
  endfunction

  function automatic m3i_pkg::ent_t any_entry();
    case ($urandom_range(0, 5))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      default: return m3i_pkg::ent_t'($urandom());
    endcase
  endfunction

  // random matrix of one of several shapes
  function automatic m3i_pkg::in_word_t random_matrix();
    m3i_pkg::ent_t e [9];
    int            kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      if (kind < 5) e[k] = small_entry();
      else if (kind < 7) e[k] = m3i_pkg::ent_t'($urandom());
      else e[k] = any_entry();
    end
    // singular: one row copies another
    if (kind == 4 || kind == 9) begin
      e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
    end
    // tiny entries give a tiny determinant, which may be zero
    if (kind == 3)
      for (int k = 0; k < 9; k++) e[k] = m3i_pkg::ent_t'($signed($urandom_range(0, 6)) - 3);
    return pack9(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
  endfunction

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words
    send_matrix(pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(pack9(2*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, -8*ONE));
    send_matrix(pack9(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(pack9(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
    send_matrix(pack9(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN));
    send_matrix(pack9(SMAX, 0, 0, 0, SMAX, 0, 0, 0, SMAX));
    send_matrix(pack9(SMIN, 0, 0, 0, SMIN, 0, 0, 0, SMIN));
    send_matrix(pack9(SMIN, SMAX, 0, SMAX, SMIN, SMAX, 0, SMAX, SMIN));
    send_matrix(pack9(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMIN));
    send_matrix(pack9(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'h5555_5555));
    send_matrix(pack9(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE));
    send_matrix(pack9(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0));
    send_matrix(pack9(ONE/2, 0, 0, 0, ONE/3, 0, 0, 0, -ONE/7));
    send_matrix(pack9(3, 1, 0, 1, 3, 1, 0, 1, 3));
    send_matrix(pack9(100*ONE, 0, 0, 0, 100*ONE, 0, 0, 0, 100*ONE));

    // hold off until the pipeline has drained
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);

    // random words
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_matrix(random_matrix());
      if (n == RANDOM_WORDS / 2) begin
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/m3i_pkg.sv
rtl/core/m3i_if.sv
rtl/core/m3i_div.sv
rtl/core/matrix3_inverse.sv
tb/matrix3_inverse_checker.sv
tb/matrix3_inverse_test.sv
